>>> rtl/assert_macros.svh
// Assertion macros used by the gate sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SGS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gate sequencer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gate sequencer assertion failed");

`endif

>>> rtl/sgs_pkg.sv
// Types and constants of the servo gate sequencer.
package sgs_pkg;

  // Gate modes, encoded as reported on gate_state.
  typedef enum logic [1:0] {
    MODE_OPENING = 2'd0,
    MODE_CLOSING = 2'd1,
    MODE_CLOSED  = 2'd2,
    MODE_OPEN    = 2'd3
  } mode_t;

  // Item kinds carried on func.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_OPEN  = 2'd1;
  localparam logic [1:0] FUNC_CLOSE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAGNET_HOLD  = 3'd0;
  localparam logic [2:0] REG_ARRIVAL_MARG = 3'd1;
  localparam logic [2:0] REG_OPEN_PULSE   = 3'd2;
  localparam logic [2:0] REG_CLOSE_PULSE  = 3'd3;
  localparam logic [2:0] REG_WINDOW_LOW   = 3'd4;
  localparam logic [2:0] REG_WINDOW_HIGH  = 3'd5;

  // Configuration reset values.
  localparam logic [31:0] RST_MAGNET_HOLD  = 32'd1000;
  localparam logic [31:0] RST_ARRIVAL_MARG = 32'd500;
  localparam logic [11:0] RST_OPEN_PULSE   = 12'd2000;
  localparam logic [11:0] RST_CLOSE_PULSE  = 12'd1000;
  localparam logic [9:0]  RST_WINDOW_LOW   = 10'd200;
  localparam logic [9:0]  RST_WINDOW_HIGH  = 10'd800;

  typedef struct packed {
    logic [31:0] magnet_hold_time;
    logic [31:0] arrival_margin;
    logic [11:0] open_pulse_width;
    logic [11:0] close_pulse_width;
    logic [9:0]  window_low;
    logic [9:0]  window_high;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now;
    logic [9:0]  arrival_level;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic        magnet_active;
    logic [31:0] magnet_start;
    logic [31:0] move_start;
    logic        servo_enabled;
    logic [11:0] pulse_width;
  } gate_reg_t;

endpackage

>>> rtl/sgs_cfg_regs.sv
// Configuration register file of the servo gate sequencer.
module sgs_cfg_regs
  import sgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output cfg_t        cfg
);

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magnet_hold_time  <= RST_MAGNET_HOLD;
      cfg.arrival_margin    <= RST_ARRIVAL_MARG;
      cfg.open_pulse_width  <= RST_OPEN_PULSE;
      cfg.close_pulse_width <= RST_CLOSE_PULSE;
      cfg.window_low        <= RST_WINDOW_LOW;
      cfg.window_high       <= RST_WINDOW_HIGH;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAGNET_HOLD:  cfg.magnet_hold_time  <= wr_data;
        REG_ARRIVAL_MARG: cfg.arrival_margin    <= wr_data;
        REG_OPEN_PULSE:   cfg.open_pulse_width  <= wr_data[11:0];
        REG_CLOSE_PULSE:  cfg.close_pulse_width <= wr_data[11:0];
        REG_WINDOW_LOW:   cfg.window_low        <= wr_data[9:0];
        REG_WINDOW_HIGH:  cfg.window_high       <= wr_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/sgs_step.sv
// Next-state logic of the gate controller for one item.
module sgs_step
  import sgs_pkg::*;
(
  input  cfg_t      cfg,
  input  item_t     item,
  input  gate_reg_t st,
  output gate_reg_t st_next,
  output logic      arrived
);

  logic        moving;
  logic [31:0] magnet_elapsed;
  logic [31:0] move_elapsed;
  logic        hold_done;
  logic        at_target;

  // Wrapping elapsed times and the arrival test.
  always_comb begin
    moving         = st.mode inside {MODE_OPENING, MODE_CLOSING};
    magnet_elapsed = item.now - st.magnet_start;
    move_elapsed   = item.now - st.move_start;
    hold_done      = st.magnet_active && (magnet_elapsed > cfg.magnet_hold_time);
    at_target      = (move_elapsed > cfg.arrival_margin) &&
                     (item.arrival_level > cfg.window_low) &&
                     (item.arrival_level < cfg.window_high);
  end

  // Mode transitions per item kind; the unused code changes nothing.
  always_comb begin
    st_next = st;
    arrived = 1'b0;
    case (item.func)
      FUNC_TICK: begin
        if (moving) begin
          if (hold_done) begin
            st_next.magnet_active = 1'b0;
            st_next.magnet_start  = '0;
          end
          if (at_target) begin
            st_next.mode          = (st.mode == MODE_OPENING) ? MODE_OPEN : MODE_CLOSED;
            st_next.servo_enabled = 1'b0;
            arrived               = 1'b1;
          end
        end
      end
      FUNC_OPEN: begin
        if (st.mode == MODE_CLOSED) begin
          st_next.mode          = MODE_OPENING;
          st_next.move_start    = item.now;
          st_next.magnet_active = 1'b1;
          st_next.magnet_start  = item.now;
          st_next.servo_enabled = 1'b1;
          st_next.pulse_width   = cfg.open_pulse_width;
        end
      end
      FUNC_CLOSE: begin
        if (st.mode == MODE_OPEN) begin
          st_next.mode          = MODE_CLOSING;
          st_next.move_start    = item.now;
          st_next.servo_enabled = 1'b1;
          st_next.pulse_width   = cfg.close_pulse_width;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/servo_gate_sequencer.sv
// Top level of the servo gate sequencer: input register, step logic, result register.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | func, now, arrival_level
//   out     | output    | out_valid/out_ready | gate_state, magnet_on, servo_on,
//           |           |                     | servo_pulse, arrived
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item's result is registered twice: the item waits in the input register and passes
// through the step logic into the result register when that register is free. One item is
// accepted per cycle while the output is not stalled; the gate state register updates as an
// item moves into the result register.
// Reset is synchronous and returns the gate to closed with the default configuration.
// A stalled output holds the result and then the input register; cfg_ready is always high.
`include "assert_macros.svh"

module servo_gate_sequencer
  import sgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] now,
  input  logic [9:0]  arrival_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  gate_state,
  output logic        magnet_on,
  output logic        servo_on,
  output logic [11:0] servo_pulse,
  output logic        arrived,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t      cfg;
  item_t     s1_item;
  logic      s1_valid;
  logic      advance;
  gate_reg_t st;
  gate_reg_t st_next;
  logic      arrived_next;
  logic      st_moving;
  logic      out_settled;

  assign cfg_ready = 1'b1;

  sgs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The item in the input register moves on when the result register is free.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item.func          <= func;
      s1_item.now           <= now;
      s1_item.arrival_level <= arrival_level;
    end
  end

  sgs_step u_step (
    .cfg     (cfg),
    .item    (s1_item),
    .st      (st),
    .st_next (st_next),
    .arrived (arrived_next)
  );

  // Gate state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode          <= MODE_CLOSED;
      st.magnet_active <= 1'b0;
      st.magnet_start  <= '0;
      st.move_start    <= '0;
      st.servo_enabled <= 1'b0;
      st.pulse_width   <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gate_state  <= st_next.mode;
      magnet_on   <= st_next.magnet_active;
      servo_on    <= st_next.servo_enabled;
      servo_pulse <= st_next.pulse_width;
      arrived     <= arrived_next;
    end
  end

  // Short terms used by the checks below.
  assign st_moving   = (st.mode == MODE_OPENING) || (st.mode == MODE_CLOSING);
  assign out_settled = (gate_state == MODE_OPEN) || (gate_state == MODE_CLOSED);

  // A completed move always leaves the gate settled with the servo released.
  `SGS_ASSERT_NOW(a_arrive_settles, clk, rst, out_valid && arrived, !servo_on && out_settled)
  // A moving gate always has its servo driven.
  `SGS_ASSERT_NOW(a_moving_servo, clk, rst, st_moving, st.servo_enabled)
  // A released magnet carries a cleared timestamp.
  `SGS_ASSERT_NOW(a_magnet_start, clk, rst, !st.magnet_active, st.magnet_start == '0)
  // The gate state only changes when an item passes into the result register.
  `SGS_ASSERT_NEXT(a_state_hold, clk, rst, !advance, $stable(st))

endmodule
